>>> design/lds_pkg.sv
`timescale 1ns / 1ps

package lds_pkg;

  localparam int MAX_ORDER  = 32;
  localparam int HIST_W     = MAX_ORDER - 1;
  localparam int TAP_W      = 32;
  localparam int ORDER_W    = 6;
  localparam int RUN_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  // input item kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RESYNC = 2'd1;
  localparam logic [1:0] KIND_SEED   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_BITS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE = 3'd4;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_RESYNC,
    OP_SEED
  } op_t;

  typedef struct packed {
    op_t  op;
    logic data_bit;
  } op_item_t;

  typedef struct packed {
    logic [TAP_W-1:0]   tap_mask;
    logic [ORDER_W-1:0] register_order;
    logic               start_mode;
    logic [TAP_W-1:0]   seed_bits;
    logic               sync_enable;
  } cfg_t;

endpackage

>>> design/lds_in_if.sv
`timescale 1ns / 1ps

interface lds_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       data_bit;

  modport source (output valid, output kind, output data_bit, input ready);
  modport sink (input valid, input kind, input data_bit, output ready);
endinterface

>>> design/lds_out_if.sv
`timescale 1ns / 1ps

interface lds_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic sync_found;
  logic current_mode;

  modport source (output valid, output out_bit, output sync_found, output current_mode,
                  input ready);
  modport sink (input valid, input out_bit, input sync_found, input current_mode,
                output ready);
endinterface

>>> design/lds_front.sv
`timescale 1ns / 1ps

module lds_front import lds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lds_in_if.sink       scrambled,
  output logic         q_valid,
  output op_item_t     q_item,
  input  logic         q_pop
);

  op_item_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                accept;
  logic                push;
  op_item_t            item_in;

  assign scrambled.ready = (count != QCNT_W'(QDEPTH));
  assign accept          = scrambled.valid && scrambled.ready;

  // classify; unused kind is taken and dropped
  always_comb begin
    item_in.data_bit = scrambled.data_bit;
    push             = accept;
    case (scrambled.kind)
      KIND_DATA:   item_in.op = OP_DATA;
      KIND_RESYNC: item_in.op = OP_RESYNC;
      KIND_SEED:   item_in.op = OP_SEED;
      default: begin
        item_in.op = OP_DATA;
        push       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

endmodule

>>> design/lds_back.sv
`timescale 1ns / 1ps

module lds_back import lds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  op_item_t     q_item,
  output logic         q_pop,
  lds_out_if.source    descrambled
);

  logic [HIST_W-1:0]  history;
  logic [HIST_W-1:0]  history_next;
  logic               feedback_prev;
  logic               feedback_prev_next;
  logic               mode;
  logic               mode_next;
  logic [RUN_W-1:0]   zero_run;
  logic [RUN_W-1:0]   zero_run_next;
  logic [RUN_W-1:0]   run_inc;
  logic [ORDER_W-1:0] order_eff;
  logic [HIST_W-1:0]  win;
  logic               fb;
  logic               y;
  logic               found;
  logic               out_valid;
  logic               out_free;
  logic               emit;

  always_comb begin
    if (cfg.register_order < ORDER_W'(2)) begin
      order_eff = ORDER_W'(2);
    end else if (cfg.register_order > ORDER_W'(MAX_ORDER)) begin
      order_eff = ORDER_W'(MAX_ORDER);
    end else begin
      order_eff = cfg.register_order;
    end
  end

  always_comb begin
    for (int i = 0; i < HIST_W; i++) begin
      win[i] = (ORDER_W'(i + 1) < order_eff);
    end
  end

  assign fb      = ^(history & cfg.tap_mask[TAP_W-1:1] & win);
  assign y       = fb ^ q_item.data_bit;
  assign run_inc = zero_run + 1'b1;

  assign out_free = !out_valid || descrambled.ready;
  assign q_pop    = q_valid && ((q_item.op != OP_DATA) || out_free);
  assign emit     = q_pop && (q_item.op == OP_DATA);

  always_comb begin
    history_next       = history;
    feedback_prev_next = feedback_prev;
    mode_next          = mode;
    zero_run_next      = zero_run;
    found              = 1'b0;
    case (q_item.op)
      OP_RESYNC: begin
        history_next  = '0;
        zero_run_next = '0;
        mode_next     = MODE_MUL;
      end
      OP_SEED: begin
        history_next = cfg.seed_bits[TAP_W-1:1] & win;
        mode_next    = cfg.start_mode;
      end
      OP_DATA: begin
        if (mode == MODE_ADD) begin
          history_next       = {history[HIST_W-2:0], feedback_prev};
          feedback_prev_next = fb;
        end else begin
          history_next = {history[HIST_W-2:0], q_item.data_bit};
          if (cfg.sync_enable) begin
            if (y) begin
              zero_run_next = '0;
            end else if (run_inc >= {order_eff, 1'b0}) begin
              zero_run_next = '0;
              mode_next     = MODE_ADD;
              found         = 1'b1;
            end else begin
              zero_run_next = run_inc;
            end
          end
        end
      end
      default: begin
        history_next = history;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history       <= '0;
      feedback_prev <= 1'b0;
      mode          <= MODE_MUL;
      zero_run      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        history       <= history_next;
        feedback_prev <= feedback_prev_next;
        mode          <= mode_next;
        zero_run      <= zero_run_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (descrambled.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      descrambled.out_bit      <= y;
      descrambled.sync_found   <= found;
      descrambled.current_mode <= mode_next;
    end
  end

  assign descrambled.valid = out_valid;

endmodule

>>> design/lfsr_descrambler_blind_sync.sv
`timescale 1ns / 1ps

// A data bit taken in is queued, then popped and registered in the output register.
// Throughput: one item per clock unless the output stalls; a two-entry queue sits
//   between intake and execution, and a single output register drives results.
// Reset (rst, synchronous, active high): queue and output emptied, history and feedback
//   cleared, mode multiplicative, zero-run count cleared, registers to their defaults.
module lfsr_descrambler_blind_sync import lds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lds_in_if.sink                scrambled,
  lds_out_if.source             descrambled,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  logic     q_valid;
  op_item_t q_item;
  logic     q_pop;

  // Configuration registers; writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_mask       <= '0;
      cfg.register_order <= ORDER_W'(2);
      cfg.start_mode     <= MODE_MUL;
      cfg.seed_bits      <= '0;
      cfg.sync_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_MASK:    cfg.tap_mask       <= cfg_data[TAP_W-1:0];
        CFG_ORDER:       cfg.register_order <= cfg_data[ORDER_W-1:0];
        CFG_START_MODE:  cfg.start_mode     <= cfg_data[0];
        CFG_SEED_BITS:   cfg.seed_bits      <= cfg_data[TAP_W-1:0];
        CFG_SYNC_ENABLE: cfg.sync_enable    <= cfg_data[0];
        default:         cfg.sync_enable    <= cfg.sync_enable;
      endcase
    end
  end

  // Intake: take every transfer while the queue has room, classify it by kind and
  // queue data, resync and seed operations. Unused kinds are taken and dropped.
  lds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .scrambled (scrambled),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Execution: advance the LFSR history, hunt for the zero run and hold each data
  // result in the output register until its transfer completes.
  lds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .descrambled (descrambled)
  );

  // A sync flag always comes with the switch to additive mode.
  a_sync_sets_additive: assert property (@(posedge clk) disable iff (rst)
    (descrambled.valid && descrambled.sync_found) |-> (descrambled.current_mode == MODE_ADD))
    else $error("sync flagged without additive mode");

  // Never pop an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.op == OP_DATA) |-> (!descrambled.valid || descrambled.ready))
    else $error("pending result overwritten");

endmodule
